>>> design/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg: shared types, constants and tables for the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
`default_nettype none
package q2e_pkg;

  localparam int AngleIterationsDefault = 14;
  localparam int MaxIterations = 24;

  // Working widths: products Q.28, sums up to 2^32, CORDIC grows by ~1.65
  localparam int SumW = 36;
  localparam int CordW = 38;
  localparam int AngW = 28;

  localparam logic signed [AngW-1:0] PiQ24 = 28'sd52707179;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [SumW-1:0] OneQ28 = 36'sd268435456;

  // Rotation order codes
  localparam logic [2:0] OrdXyz = 3'd0;
  localparam logic [2:0] OrdYxz = 3'd1;
  localparam logic [2:0] OrdZxy = 3'd2;
  localparam logic [2:0] OrdZyx = 3'd3;
  localparam logic [2:0] OrdYzx = 3'd4;
  localparam logic [2:0] OrdXzy = 3'd5;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } euler_t;

  function automatic logic signed [AngW-1:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0: atan_tab = 28'sd13176795;
      5'd1: atan_tab = 28'sd7778716;
      5'd2: atan_tab = 28'sd4110060;
      5'd3: atan_tab = 28'sd2086331;
      5'd4: atan_tab = 28'sd1047214;
      5'd5: atan_tab = 28'sd524117;
      5'd6: atan_tab = 28'sd262123;
      5'd7: atan_tab = 28'sd131069;
      default: atan_tab = AngW'(28'sd65536 >>> (i - 5'd8));
    endcase
  endfunction

endpackage
`default_nettype wire

>>> design/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion (Q2.14) to three Euler angles
// (Q3.13 radians) for one of six axis orders.
//
// Usage:
//   Drive quat_i and pulse start_i; an item is taken whenever start_i is high
//   (busy_o is always low, so one item per cycle is accepted).
//   Each result appears on euler_o for one cycle with done_o high, in order.
//   The pipeline is three front stages (products, sums, square), a 29-stage
//   square root that feeds the asin angle, then a CORDIC of ANGLE_ITERATIONS
//   stages plus an input and a rounding register. The operands of the two
//   atan2 angles travel through the square root beside it, so all three
//   CORDICs start together. Throughput is one item per cycle.
//   The receiver cannot stall; results are never held.
//   rotation_order is written with order_we_i/order_i; the user does so only while idle,
//   the block does not enforce it. Reset sets it to XYZ. Codes 6 and 7 act as XYZ. Reset empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int ANGLE_ITERATIONS = q2e_pkg::AngleIterationsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire q2e_pkg::quat_t  quat_i,
  input  wire logic            order_we_i,
  input  wire logic [2:0]      order_i,
  output logic                 done_o,
  output q2e_pkg::euler_t      euler_o
);

  localparam int SW = q2e_pkg::SumW;

  logic [2:0] order_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= q2e_pkg::OrdXyz;
    else if (order_we_i) order_q <= order_i;
  end

  assign busy_o = 1'b0;

  logic                 f_vld;
  logic [2:0]           f_ord;
  logic signed [SW-1:0] f_na, f_da, f_nb, f_db, f_av;
  logic [56:0]          f_rad;

  q2e_front u_front (
    .clk_i, .rst_ni,
    .valid_i(start_i), .quat_i, .order_i(order_q),
    .valid_o(f_vld), .order_o(f_ord),
    .num_a_o(f_na), .den_a_o(f_da), .num_b_o(f_nb), .den_b_o(f_db),
    .asin_v_o(f_av), .rad_o(f_rad)
  );

  // square root carries the other operands so all three CORDICs start together
  localparam int SideW = 3 + 5 * SW;
  logic             s_vld;
  logic [28:0]      s_root;
  logic [SideW-1:0] s_side;

  q2e_sqrt #(.SideW(SideW)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i(f_vld), .rad_i(f_rad),
    .side_i({f_ord, f_na, f_da, f_nb, f_db, f_av}),
    .valid_o(s_vld), .root_o(s_root), .side_o(s_side)
  );

  logic [2:0]           s_ord;
  logic signed [SW-1:0] s_na, s_da, s_nb, s_db, s_av;
  assign {s_ord, s_na, s_da, s_nb, s_db, s_av} = s_side;

  logic                 va, vb, vc;
  logic signed [15:0]   ang_a, ang_b, ang_c;

  q2e_cordic #(.Iterations(ANGLE_ITERATIONS)) u_cord_a (
    .clk_i, .rst_ni, .valid_i(s_vld), .num_i(s_na), .den_i(s_da),
    .valid_o(va), .angle_o(ang_a)
  );
  q2e_cordic #(.Iterations(ANGLE_ITERATIONS)) u_cord_b (
    .clk_i, .rst_ni, .valid_i(s_vld), .num_i(s_nb), .den_i(s_db),
    .valid_o(vb), .angle_o(ang_b)
  );
  q2e_cordic #(.Iterations(ANGLE_ITERATIONS)) u_cord_c (
    .clk_i, .rst_ni, .valid_i(s_vld), .num_i(s_av), .den_i(SW'(s_root)),
    .valid_o(vc), .angle_o(ang_c)
  );

  // order travels beside the CORDICs
  localparam int CLat = ANGLE_ITERATIONS + 2;
  logic [2:0] ord_dly_q [CLat];
  always_ff @(posedge clk_i) begin
    ord_dly_q[0] <= s_ord;
    for (int k = 1; k < CLat; k++) ord_dly_q[k] <= ord_dly_q[k-1];
  end
  logic [2:0] o_ord;
  assign o_ord = ord_dly_q[CLat-1];

  // map: a and b are the two atan2 angles, c the asin angle
  always_comb begin
    case (o_ord)
      q2e_pkg::OrdYxz, q2e_pkg::OrdZxy: begin
        euler_o.angle_x = ang_c; euler_o.angle_y = ang_a; euler_o.angle_z = ang_b;
      end
      q2e_pkg::OrdYzx, q2e_pkg::OrdXzy: begin
        euler_o.angle_x = ang_a; euler_o.angle_y = ang_b; euler_o.angle_z = ang_c;
      end
      default: begin
        euler_o.angle_x = ang_a; euler_o.angle_y = ang_c; euler_o.angle_z = ang_b;
      end
    endcase
  end

  assign done_o = va & vb & vc;

endmodule
`default_nettype wire

>>> design/q2e_sqrt.sv
// ----------------------------------------------------------------------------
// q2e_sqrt: pipelined restoring square root, one result bit per stage.
// Floor sqrt of a 57-bit value, 29 stages; an operand travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_sqrt #(
  parameter int SideW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [56:0]      rad_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [28:0]           root_o,
  output logic [SideW-1:0]      side_o
);

  localparam int Steps = 29;

  logic [Steps:0]   vld_q;
  logic [57:0]      rem_q  [Steps+1];
  logic [57:0]      res_q  [Steps+1];
  logic [SideW-1:0] side_q [Steps+1];

  always_comb begin
    rem_q[0] = {1'b0, rad_i};
    res_q[0] = '0;
    side_q[0] = side_i;
    vld_q[0] = valid_i;
  end

  // one digit per stage
  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [57:0] Bit = 58'd1 << (56 - 2 * k);
    logic [57:0] trial;
    logic [57:0] rem_d, res_d;
    always_comb begin
      trial = res_q[k] + Bit;
      if (rem_q[k] >= trial) begin
        rem_d = rem_q[k] - trial;
        res_d = (res_q[k] >> 1) + Bit;
      end else begin
        rem_d = rem_q[k];
        res_d = res_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      res_q[k+1] <= res_d;
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o = res_q[Steps][28:0];
  assign side_o = side_q[Steps];

endmodule
`default_nettype wire

>>> design/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic: pipelined vectoring CORDIC atan2, one rotation per stage up to
// MaxIterations, followed by rounding to Q3.13 with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_cordic #(
  parameter int Iterations = q2e_pkg::AngleIterationsDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  input  wire logic signed [q2e_pkg::SumW-1:0]      num_i,
  input  wire logic signed [q2e_pkg::SumW-1:0]      den_i,
  output logic                                      valid_o,
  output logic signed [15:0]                        angle_o
);

  localparam int CW = q2e_pkg::CordW;
  localparam int AW = q2e_pkg::AngW;

  logic [Iterations:0]  vld_q;
  logic signed [CW-1:0] x_q [Iterations+1];
  logic signed [CW-1:0] y_q [Iterations+1];
  logic signed [AW-1:0] a_q [Iterations+1];
  logic [Iterations:0]  zero_q;

  // pre-rotation by pi for a negative denominator
  logic signed [CW-1:0] x0, y0;
  logic signed [AW-1:0] a0;
  always_comb begin
    x0 = CW'(den_i);
    y0 = CW'(num_i);
    a0 = '0;
    if (den_i < 0) begin
      a0 = (num_i >= 0) ? q2e_pkg::PiQ24 : -q2e_pkg::PiQ24;
      x0 = -x0;
      y0 = -y0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    x_q[0] <= x0;
    y_q[0] <= y0;
    a_q[0] <= a0;
    zero_q[0] <= (den_i == 0) && (num_i == 0);
  end

  for (genvar i = 0; i < Iterations; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    logic signed [AW-1:0] da;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign da = (i < q2e_pkg::MaxIterations) ? q2e_pkg::atan_tab(5'(i)) : '0;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (i >= q2e_pkg::MaxIterations) begin
        x_q[i+1] <= x_q[i];
        y_q[i+1] <= y_q[i];
        a_q[i+1] <= a_q[i];
      end else if (y_q[i] >= 0) begin
        x_q[i+1] <= x_q[i] + dy;
        y_q[i+1] <= y_q[i] - dx;
        a_q[i+1] <= a_q[i] + da;
      end else begin
        x_q[i+1] <= x_q[i] - dy;
        y_q[i+1] <= y_q[i] + dx;
        a_q[i+1] <= a_q[i] - da;
      end
      zero_q[i+1] <= zero_q[i];
    end
  end

  // round half up to Q.13 and saturate to +-pi
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] sat;
  always_comb begin
    rnd = (a_q[Iterations] + AW'(1024)) >>> 11;
    if (rnd > AW'(q2e_pkg::PiQ13)) sat = AW'(q2e_pkg::PiQ13);
    else if (rnd < -AW'(q2e_pkg::PiQ13)) sat = -AW'(q2e_pkg::PiQ13);
    else sat = rnd;
  end

  logic signed [15:0] ang_q;
  logic               out_vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[Iterations];
    end
  end
  always_ff @(posedge clk_i) begin
    ang_q <= zero_q[Iterations] ? '0 : sat[15:0];
  end

  assign valid_o = out_vld_q;
  assign angle_o = ang_q;

endmodule
`default_nettype wire

>>> design/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front: component products and order-dependent sums.
// Stage 1: products. Stage 2: sums and asin clamp. Stage 3: 1 - v*v.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire q2e_pkg::quat_t                    quat_i,
  input  wire logic [2:0]                        order_i,
  output logic                                   valid_o,
  output logic [2:0]                             order_o,
  output logic signed [q2e_pkg::SumW-1:0]        num_a_o,
  output logic signed [q2e_pkg::SumW-1:0]        den_a_o,
  output logic signed [q2e_pkg::SumW-1:0]        num_b_o,
  output logic signed [q2e_pkg::SumW-1:0]        den_b_o,
  output logic signed [q2e_pkg::SumW-1:0]        asin_v_o,
  output logic [56:0]                            rad_o
);

  localparam int SW = q2e_pkg::SumW;

  // stage 1: products
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xw_q, yz_q, xz_q, yw_q, xy_q, zw_q;
  logic [2:0] ord1_q;
  logic       v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    ww_q <= quat_i.quat_w * quat_i.quat_w;
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;
    xw_q <= quat_i.quat_x * quat_i.quat_w;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    xz_q <= quat_i.quat_x * quat_i.quat_z;
    yw_q <= quat_i.quat_y * quat_i.quat_w;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    zw_q <= quat_i.quat_z * quat_i.quat_w;
    ord1_q <= order_i;
  end

  // stage 2: sums per order
  logic signed [SW-1:0] ww, xx, yy, zz, xw, yz, xz, yw, xy, zw;
  logic signed [SW-1:0] d_mmp, d_mpm, d_pmm;
  logic signed [SW-1:0] na, da, nb, db, av, avc;
  always_comb begin
    ww = SW'(ww_q); xx = SW'(xx_q); yy = SW'(yy_q); zz = SW'(zz_q);
    xw = SW'(xw_q); yz = SW'(yz_q); xz = SW'(xz_q); yw = SW'(yw_q);
    xy = SW'(xy_q); zw = SW'(zw_q);
    d_mmp = ww - xx - yy + zz;
    d_mpm = ww - xx + yy - zz;
    d_pmm = ww + xx - yy - zz;
    case (ord1_q)
      q2e_pkg::OrdYxz: begin
        av = (xw - yz) <<< 1;
        na = (xz + yw) <<< 1; da = d_mmp;
        nb = (xy + zw) <<< 1; db = d_mpm;
      end
      q2e_pkg::OrdZxy: begin
        av = (xw + yz) <<< 1;
        na = (yw - xz) <<< 1; da = d_mmp;
        nb = (zw - xy) <<< 1; db = d_mpm;
      end
      q2e_pkg::OrdZyx: begin
        av = (yw - xz) <<< 1;
        na = (xw + yz) <<< 1; da = d_mmp;
        nb = (xy + zw) <<< 1; db = d_pmm;
      end
      q2e_pkg::OrdYzx: begin
        av = (xy + zw) <<< 1;
        na = (xw - yz) <<< 1; da = d_mpm;
        nb = (yw - xz) <<< 1; db = d_pmm;
      end
      q2e_pkg::OrdXzy: begin
        av = (zw - xy) <<< 1;
        na = (xw + yz) <<< 1; da = d_mpm;
        nb = (xz + yw) <<< 1; db = d_pmm;
      end
      default: begin
        av = (xz + yw) <<< 1;
        na = (xw - yz) <<< 1; da = d_mmp;
        nb = (zw - xy) <<< 1; db = d_pmm;
      end
    endcase
    if (av > q2e_pkg::OneQ28) avc = q2e_pkg::OneQ28;
    else if (av < -q2e_pkg::OneQ28) avc = -q2e_pkg::OneQ28;
    else avc = av;
  end

  logic signed [SW-1:0] na_q, da_q, nb_q, db_q, av_q;
  logic [2:0] ord2_q;
  logic       v2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    na_q <= na; da_q <= da; nb_q <= nb; db_q <= db; av_q <= avc;
    ord2_q <= ord1_q;
  end

  // stage 3: 1 - v*v, |v| <= 2^28 so a 29x29 product
  logic [28:0] vabs;
  logic [57:0] vsq;
  assign vabs = av_q[SW-1] ? 29'(-av_q) : 29'(av_q);
  assign vsq = vabs * vabs;

  logic signed [SW-1:0] na3_q, da3_q, nb3_q, db3_q, av3_q;
  logic [56:0] rad_q;
  logic [2:0]  ord3_q;
  logic        v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    rad_q <= 57'((58'd1 << 56) - vsq);
    na3_q <= na_q; da3_q <= da_q; nb3_q <= nb_q; db3_q <= db_q; av3_q <= av_q;
    ord3_q <= ord2_q;
  end

  assign valid_o = v3_q;
  assign order_o = ord3_q;
  assign num_a_o = na3_q;
  assign den_a_o = da3_q;
  assign num_b_o = nb3_q;
  assign den_b_o = db3_q;
  assign asin_v_o = av3_q;
  assign rad_o = rad_q;

endmodule
`default_nettype wire

>>> design/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker: port-level properties of the converter.
// ----------------------------------------------------------------------------
`default_nettype none
module q2e_checker #(
  parameter int Iterations = q2e_pkg::AngleIterationsDefault
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            start_i,
  input wire logic            busy_o,
  input wire logic            done_o,
  input wire q2e_pkg::euler_t euler_o
);

  localparam int Lat = 3 + 29 + Iterations + 2;

  // each result on done_o must come from an item taken on start_i
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##Lat done_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without matching item");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_range_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (euler_o.angle_x <= q2e_pkg::PiQ13 && euler_o.angle_x >= -q2e_pkg::PiQ13))
    else $error("angle_x out of range");

  a_range_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (euler_o.angle_z <= q2e_pkg::PiQ13 && euler_o.angle_z >= -q2e_pkg::PiQ13))
    else $error("angle_z out of range");

endmodule

bind quaternion_to_euler_angles q2e_checker #(.Iterations(ANGLE_ITERATIONS)) u_q2e_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .euler_o
);
`default_nettype wire
